// ===== rtl/core/ntp_s2c_pkg.sv =====
// ----------------------------------------------------------------------------
// ntp_s2c_pkg: constants for the NTP seconds to calendar converter
// Calendar constants and fixed-point reciprocals for the constant divides.
// ----------------------------------------------------------------------------
package ntp_s2c_pkg;

    localparam int NUM_STAGES = 12;

    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
    localparam logic [17:0] DAYS_PER_400Y  = 18'd146097;
    localparam logic [10:0] DAYS_PER_4Y    = 11'd1461;
    localparam logic [7:0]  DAYS_PER_5MON  = 8'd153;
    localparam logic [6:0]  YEARS_PER_CENT = 7'd100;

    localparam logic [21:0] JDN_JAN_1ST_1900 = 22'd2415021;
    localparam logic [21:0] JDN_MARCH_BASE   = 22'd1721119;
    localparam logic [19:0] MARCH_OFFSET     = 20'(JDN_JAN_1ST_1900 - JDN_MARCH_BASE);

    // q = (x * RECIP) >> SHIFT, with SHIFT = input bits + ceil(log2(divisor)),
    // RECIP = ceil(2^SHIFT / divisor); exact over the whole input range.
    localparam int DAY_SHIFT = 35;    // x = seconds >> 7 (25 bits), divisor 675
    localparam logic [25:0] DAY_RECIP =
        26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);

    localparam int CENT_SHIFT = 40;   // 22-bit input, divisor 146097
    localparam logic [22:0] CENT_RECIP =
        23'(((64'd1 << CENT_SHIFT) + 64'd146096) / 64'd146097);

    localparam int HOUR_SHIFT = 29;   // 17-bit input, divisor 3600
    localparam logic [17:0] HOUR_RECIP =
        18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);

    localparam int YEAR_SHIFT = 29;   // 18-bit input, divisor 1461
    localparam logic [18:0] YEAR_RECIP =
        19'(((64'd1 << YEAR_SHIFT) + 64'd1460) / 64'd1461);

    localparam int MIN_SHIFT = 18;    // 12-bit input, divisor 60
    localparam logic [12:0] MIN_RECIP =
        13'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

    localparam int MON_SHIFT = 19;    // 11-bit input, divisor 153
    localparam logic [11:0] MON_RECIP =
        12'(((64'd1 << MON_SHIFT) + 64'd152) / 64'd153);

    localparam int DAY5_SHIFT = 11;   // 8-bit input, divisor 5
    localparam logic [8:0] DAY5_RECIP =
        9'(((64'd1 << DAY5_SHIFT) + 64'd4) / 64'd5);

    localparam logic [3:0] MONTH_WRAP = 4'd10;

endpackage

// ===== rtl/core/ntp_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar: NTP seconds to Gregorian date and time of day
// Throughput: one request per cycle; a stalled output holds only the stages
// that cannot move, bubbles ahead of it still fill.
// The depth is set by the constant-reciprocal multipliers, each followed by a
// register before its product is used.
// Reset clears the stage valid bits only; the datapath is not reset.
// ----------------------------------------------------------------------------
module ntp_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] ntp_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);
    import ntp_s2c_pkg::*;

    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] stage_en;

    // stage 1
    logic [31:0] s1_sec_reg;
    logic [50:0] s1_prod_reg;
    // stage 2
    logic [31:0] s2_sec_reg;
    logic [15:0] s2_days_reg;
    // stage 3
    logic [16:0] s3_rem_reg;
    logic [21:0] s3_t_reg;
    // stage 4
    logic [16:0] s4_rem_reg;
    logic [21:0] s4_t_reg;
    logic [44:0] s4_pc_reg;
    logic [34:0] s4_ph_reg;
    // stage 5
    logic [4:0]  s5_c_reg;
    logic [17:0] s5_j2_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_rem2_reg;
    // stage 6
    logic [4:0]  s6_c_reg;
    logic [17:0] s6_t2_reg;
    logic [36:0] s6_py_reg;
    logic [4:0]  s6_hour_reg;
    logic [11:0] s6_rem2_reg;
    logic [24:0] s6_pm_reg;
    // stage 7
    logic [4:0]  s7_c_reg;
    logic [6:0]  s7_y_reg;
    logic [10:0] s7_d2_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg;
    logic [5:0]  s7_sec_reg;
    // stage 8
    logic [4:0]  s8_c_reg;
    logic [6:0]  s8_y_reg;
    logic [10:0] s8_t3_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg;
    logic [5:0]  s8_sec_reg;
    // stage 9
    logic [4:0]  s9_c_reg;
    logic [6:0]  s9_y_reg;
    logic [10:0] s9_t3_reg;
    logic [22:0] s9_pmo_reg;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_min_reg;
    logic [5:0]  s9_sec_reg;
    // stage 10
    logic [4:0]  s10_c_reg;
    logic [6:0]  s10_y_reg;
    logic [3:0]  s10_m_reg;
    logic [7:0]  s10_d4_reg;
    logic [4:0]  s10_hour_reg;
    logic [5:0]  s10_min_reg;
    logic [5:0]  s10_sec_reg;
    // stage 11
    logic [4:0]  s11_c_reg;
    logic [6:0]  s11_y_reg;
    logic [3:0]  s11_m_reg;
    logic [16:0] s11_pd_reg;
    logic [4:0]  s11_hour_reg;
    logic [5:0]  s11_min_reg;
    logic [5:0]  s11_sec_reg;
    // stage 12 (output)
    logic [10:0] s12_year_reg;
    logic [3:0]  s12_month_reg;
    logic [4:0]  s12_day_reg;
    logic [4:0]  s12_hour_reg;
    logic [5:0]  s12_min_reg;
    logic [5:0]  s12_sec_reg;

    // next values
    logic [50:0] s1_prod_next;
    logic [16:0] s3_rem_next;
    logic [19:0] s3_j_next;
    logic [21:0] s3_t_next;
    logic [4:0]  s5_c_next;
    logic [4:0]  s5_hour_next;
    logic [17:0] s5_j2_next;
    logic [11:0] s5_rem2_next;
    logic [17:0] s6_t2_next;
    logic [6:0]  s7_y_next;
    logic [5:0]  s7_min_next;
    logic [10:0] s7_d2_next;
    logic [5:0]  s7_sec_next;
    logic [8:0]  s8_d3_next;
    logic [10:0] s8_t3_next;
    logic [3:0]  s10_m_next;
    logic [7:0]  s10_d4_next;
    logic [8:0]  s11_dp5_next;
    logic        s12_wrap_next;
    logic [10:0] s12_year_next;
    logic [3:0]  s12_month_next;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        stage_en[NUM_STAGES] = !valid_reg[NUM_STAGES] || out_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    always_comb
    begin
        s1_prod_next  = 51'(ntp_seconds[31:7]) * 51'(DAY_RECIP);
        s3_rem_next   = 17'(s2_sec_reg - 32'(s2_days_reg) * 32'(SECS_PER_DAY));
        s3_j_next     = 20'(s2_days_reg) + MARCH_OFFSET;
        s3_t_next     = {s3_j_next, 2'b00} - 22'd1;
        s5_c_next     = s4_pc_reg[CENT_SHIFT + 4:CENT_SHIFT];
        s5_hour_next  = s4_ph_reg[HOUR_SHIFT + 4:HOUR_SHIFT];
        s5_j2_next    = 18'(s4_t_reg - 22'(s5_c_next) * 22'(DAYS_PER_400Y));
        s5_rem2_next  = 12'(s4_rem_reg - 17'(s5_hour_next) * 17'(SECS_PER_HOUR));
        s6_t2_next    = {s5_j2_reg[17:2], 2'b11};
        s7_y_next     = s6_py_reg[YEAR_SHIFT + 6:YEAR_SHIFT];
        s7_min_next   = s6_pm_reg[MIN_SHIFT + 5:MIN_SHIFT];
        s7_d2_next    = 11'(s6_t2_reg - 18'(s7_y_next) * 18'(DAYS_PER_4Y));
        s7_sec_next   = 6'(s6_rem2_reg - 12'(s7_min_next) * 12'(SECS_PER_MIN));
        s8_d3_next    = 9'((12'(s7_d2_reg) + 12'd4) >> 2);
        s8_t3_next    = 11'({s8_d3_next, 2'b00}) + 11'(s8_d3_next) - 11'd3;
        s10_m_next    = s9_pmo_reg[MON_SHIFT + 3:MON_SHIFT];
        s10_d4_next   = 8'(s9_t3_reg - 11'(s10_m_next) * 11'(DAYS_PER_5MON));
        s11_dp5_next  = 9'(s10_d4_reg) + 9'd5;
        s12_wrap_next = (s11_m_reg >= MONTH_WRAP);
        s12_year_next = 11'(s11_c_reg) * 11'(YEARS_PER_CENT) + 11'(s11_y_reg)
                        + 11'(s12_wrap_next);
        s12_month_next = s12_wrap_next ? (s11_m_reg - 4'd9) : (s11_m_reg + 4'd3);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s1_sec_reg  <= ntp_seconds;
            s1_prod_reg <= s1_prod_next;
        end
        if (stage_en[2])
        begin
            s2_sec_reg  <= s1_sec_reg;
            s2_days_reg <= s1_prod_reg[DAY_SHIFT + 15:DAY_SHIFT];
        end
        if (stage_en[3])
        begin
            s3_rem_reg <= s3_rem_next;
            s3_t_reg   <= s3_t_next;
        end
        if (stage_en[4])
        begin
            s4_rem_reg <= s3_rem_reg;
            s4_t_reg   <= s3_t_reg;
            s4_pc_reg  <= 45'(s3_t_reg) * 45'(CENT_RECIP);
            s4_ph_reg  <= 35'(s3_rem_reg) * 35'(HOUR_RECIP);
        end
        if (stage_en[5])
        begin
            s5_c_reg    <= s5_c_next;
            s5_j2_reg   <= s5_j2_next;
            s5_hour_reg <= s5_hour_next;
            s5_rem2_reg <= s5_rem2_next;
        end
        if (stage_en[6])
        begin
            s6_c_reg    <= s5_c_reg;
            s6_t2_reg   <= s6_t2_next;
            s6_py_reg   <= 37'(s6_t2_next) * 37'(YEAR_RECIP);
            s6_hour_reg <= s5_hour_reg;
            s6_rem2_reg <= s5_rem2_reg;
            s6_pm_reg   <= 25'(s5_rem2_reg) * 25'(MIN_RECIP);
        end
        if (stage_en[7])
        begin
            s7_c_reg    <= s6_c_reg;
            s7_y_reg    <= s7_y_next;
            s7_d2_reg   <= s7_d2_next;
            s7_hour_reg <= s6_hour_reg;
            s7_min_reg  <= s7_min_next;
            s7_sec_reg  <= s7_sec_next;
        end
        if (stage_en[8])
        begin
            s8_c_reg    <= s7_c_reg;
            s8_y_reg    <= s7_y_reg;
            s8_t3_reg   <= s8_t3_next;
            s8_hour_reg <= s7_hour_reg;
            s8_min_reg  <= s7_min_reg;
            s8_sec_reg  <= s7_sec_reg;
        end
        if (stage_en[9])
        begin
            s9_c_reg    <= s8_c_reg;
            s9_y_reg    <= s8_y_reg;
            s9_t3_reg   <= s8_t3_reg;
            s9_pmo_reg  <= 23'(s8_t3_reg) * 23'(MON_RECIP);
            s9_hour_reg <= s8_hour_reg;
            s9_min_reg  <= s8_min_reg;
            s9_sec_reg  <= s8_sec_reg;
        end
        if (stage_en[10])
        begin
            s10_c_reg    <= s9_c_reg;
            s10_y_reg    <= s9_y_reg;
            s10_m_reg    <= s10_m_next;
            s10_d4_reg   <= s10_d4_next;
            s10_hour_reg <= s9_hour_reg;
            s10_min_reg  <= s9_min_reg;
            s10_sec_reg  <= s9_sec_reg;
        end
        if (stage_en[11])
        begin
            s11_c_reg    <= s10_c_reg;
            s11_y_reg    <= s10_y_reg;
            s11_m_reg    <= s10_m_reg;
            s11_pd_reg   <= 17'(s11_dp5_next) * 17'(DAY5_RECIP);
            s11_hour_reg <= s10_hour_reg;
            s11_min_reg  <= s10_min_reg;
            s11_sec_reg  <= s10_sec_reg;
        end
        if (stage_en[12])
        begin
            s12_year_reg  <= s12_year_next;
            s12_month_reg <= s12_month_next;
            s12_day_reg   <= s11_pd_reg[DAY5_SHIFT + 4:DAY5_SHIFT];
            s12_hour_reg  <= s11_hour_reg;
            s12_min_reg   <= s11_min_reg;
            s12_sec_reg   <= s11_sec_reg;
        end
    end

    assign in_ready     = stage_en[1];
    assign out_valid    = valid_reg[NUM_STAGES];
    assign year         = s12_year_reg;
    assign month        = s12_month_reg;
    assign day_of_month = s12_day_reg;
    assign hour         = s12_hour_reg;
    assign minute       = s12_min_reg;
    assign second       = s12_sec_reg;

`ifndef NO_ASSERTIONS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[1])
        else $error("accepted request did not enter stage 1");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> month >= 4'd1 && month <= 4'd12
                   && day_of_month >= 5'd1 && day_of_month <= 5'd31)
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour < 5'd24 && minute < 6'd60 && second < 6'd60)
        else $error("time of day out of range");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg) && !out_ready)
        else $error("input blocked while pipeline has a bubble");

    a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NUM_STAGES - 1] && !stage_en[NUM_STAGES]
        |=> valid_reg[NUM_STAGES - 1])
        else $error("item lost in stalled stage");
`endif

endmodule
